// ----- rtl/core/ufsef_pkg.sv -----
package ufsef_pkg;

    localparam int UFSEF_NODE_COUNT = 16384;

    localparam int NODE_W   = 14;
    localparam int WEIGHT_W = 17;
    localparam int COUNT_W  = 17;
    localparam int FIELD_W  = 2 * NODE_W + WEIGHT_W;
    localparam int DATA_W   = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W    = DATA_W - FIELD_W;
    localparam int USER_W   = 1;

    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_EDGE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_COMP_RD,
        ST_COMP_WR,
        ST_LINK
    } ufsef_state_t;

    typedef struct packed {
        logic clr_init;
        logic clr_wr;
        logic load;
        logic rd_en;
        logic rd_from_data;
        logic cur_adv;
        logic find_done;
        logic sel_dst;
        logic save_ra;
        logic comp_wr;
        logic link;
    } ufsef_cmd_t;

    typedef struct packed {
        logic in_range;
        logic rd_hit;
        logic cur_is_root;
        logic next_is_root;
        logic roots_equal;
        logic clr_last;
        logic out_free;
    } ufsef_stat_t;

endpackage

// ----- rtl/core/ufsef_ram.sv -----
module ufsef_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/ufsef_ctrl.sv -----
module ufsef_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic                  s_axis_tuser,
    input  ufsef_pkg::ufsef_stat_t stat,
    output ufsef_pkg::ufsef_cmd_t  cmd
);

    import ufsef_pkg::*;

    ufsef_state_t state_reg, state_next;
    logic         side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == KIND_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (stat.in_range)
                    begin
                        state_next = ST_FIND_RD;
                        side_next  = 1'b0;
                    end
                end
            end
            ST_FIND_RD:
            begin
                state_next = ST_FIND_CHK;
            end
            ST_FIND_CHK:
            begin
                if (stat.rd_hit)
                begin
                    state_next = ST_COMP_RD;
                end
            end
            ST_COMP_RD:
            begin
                if (stat.cur_is_root)
                begin
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = ST_FIND_RD;
                    end
                    else if (stat.roots_equal)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    state_next = ST_COMP_WR;
                end
            end
            ST_COMP_WR:
            begin
                if (stat.next_is_root)
                begin
                    state_next = ST_COMP_RD;
                end
            end
            ST_LINK:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        cmd.sel_dst   = side_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.clr_init = (s_axis_tuser == KIND_CLEAR);
                    cmd.load     = (s_axis_tuser == KIND_EDGE) && stat.in_range;
                end
            end
            ST_FIND_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_FIND_CHK:
            begin
                if (stat.rd_hit)
                begin
                    cmd.find_done = 1'b1;
                end
                else
                begin
                    cmd.rd_en        = 1'b1;
                    cmd.rd_from_data = 1'b1;
                    cmd.cur_adv      = 1'b1;
                end
            end
            ST_COMP_RD:
            begin
                if (stat.cur_is_root)
                begin
                    cmd.save_ra = !side_reg;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            ST_COMP_WR:
            begin
                cmd.comp_wr = 1'b1;
                cmd.cur_adv = 1'b1;
                if (!stat.next_is_root)
                begin
                    cmd.rd_en        = 1'b1;
                    cmd.rd_from_data = 1'b1;
                end
            end
            ST_LINK:
            begin
                cmd.link = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/ufsef_dp.sv -----
module ufsef_dp #(
    parameter int NODE_COUNT = ufsef_pkg::UFSEF_NODE_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ufsef_pkg::ufsef_cmd_t         cmd,
    output ufsef_pkg::ufsef_stat_t        stat,
    input  logic [ufsef_pkg::DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ufsef_pkg::DATA_W-1:0]  m_axis_tdata
);

    import ufsef_pkg::*;

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [COUNT_W-1:0] NODE_LIMIT = COUNT_W'(NODE_COUNT);
    localparam logic [AW-1:0]      LAST_ADDR  = AW'(NODE_COUNT - 1);

    logic [NODE_W-1:0]   in_src;
    logic [NODE_W-1:0]   in_dst;
    logic [WEIGHT_W-1:0] in_weight;

    logic [NODE_W-1:0]   src_reg, dst_reg, cur_reg, cur_next, root_reg, ra_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg;

    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [NODE_W-1:0]   wr_data, rd_data;

    assign in_src    = s_axis_tdata[NODE_W-1:0];
    assign in_dst    = s_axis_tdata[2*NODE_W-1:NODE_W];
    assign in_weight = s_axis_tdata[FIELD_W-1:2*NODE_W];

    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.load)
        begin
            cur_next = in_src;
        end
        else if (cmd.find_done)
        begin
            cur_next = cmd.sel_dst ? dst_reg : src_reg;
        end
        else if (cmd.save_ra)
        begin
            cur_next = dst_reg;
        end
        else if (cmd.cur_adv)
        begin
            cur_next = rd_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.load)
        begin
            src_reg <= in_src;
            dst_reg <= in_dst;
            w_reg   <= in_weight;
        end
        if (cmd.find_done)
        begin
            root_reg <= cur_reg;
        end
        if (cmd.save_ra)
        begin
            ra_reg <= root_reg;
        end
        if (cmd.link)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, w_reg, dst_reg, src_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_init)
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.link)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sweep writes, path rewrites and the final root link share one port
    always_comb
    begin
        wr_en = cmd.clr_wr || cmd.comp_wr || cmd.link;
        if (cmd.clr_wr)
        begin
            wr_addr = clr_cnt_reg;
            wr_data = NODE_W'(clr_cnt_reg);
        end
        else if (cmd.comp_wr)
        begin
            wr_addr = AW'(cur_reg);
            wr_data = root_reg;
        end
        else
        begin
            wr_addr = AW'(ra_reg);
            wr_data = root_reg;
        end
    end

    assign rd_en   = cmd.rd_en;
    assign rd_addr = cmd.rd_from_data ? AW'(rd_data) : AW'(cur_reg);

    ufsef_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT),
        .AW    (AW)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.in_range     = ({{(COUNT_W-NODE_W){1'b0}}, in_src} < NODE_LIMIT) &&
                               ({{(COUNT_W-NODE_W){1'b0}}, in_dst} < NODE_LIMIT);
    assign stat.rd_hit       = (rd_data == cur_reg);
    assign stat.cur_is_root  = (cur_reg == root_reg);
    assign stat.next_is_root = (rd_data == root_reg);
    assign stat.roots_equal  = (ra_reg == root_reg);
    assign stat.clr_last     = (clr_cnt_reg == LAST_ADDR);
    assign stat.out_free     = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- rtl/core/union_find_spanning_edge_filter.sv -----
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: src_node, dst_node, weight; tuser: kind
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_src, out_dst, out_weight
//
// One transaction at a time, set by the single read port of the parent memory: an edge
// is accepted, each endpoint is walked to its root and its path rewritten to point at
// that root, and a link step follows when the roots differ.
// After reset and after every clear transaction a sweep rewrites all NODE_COUNT entries,
// one per cycle, with s_axis_tready held low; an out-of-range edge is dropped on acceptance.
// A waiting result stalls the next edge only at its link step, until m_axis takes it.
module union_find_spanning_edge_filter #(
    parameter int NODE_COUNT = ufsef_pkg::UFSEF_NODE_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // src_node [13:0], dst_node [27:14], weight [44:28], zero pad [47:45]
    input  logic [ufsef_pkg::DATA_W-1:0]  s_axis_tdata,
    // kind [0]: 0 = clear forest, 1 = process edge
    input  logic [ufsef_pkg::USER_W-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_src [13:0], out_dst [27:14], out_weight [44:28], zero pad [47:45]
    output logic [ufsef_pkg::DATA_W-1:0]  m_axis_tdata
);

    import ufsef_pkg::*;

    ufsef_cmd_t  cmd;
    ufsef_stat_t stat;

    // sequence the sweep, the two root walks, the path rewrites and the link
    ufsef_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser[0]),
        .stat          (stat),
        .cmd           (cmd)
    );

    // hold the edge, the walk pointer, both roots, the parent memory and the result
    ufsef_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
